[rtl/ddo_pkg.sv]
package ddo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int POS_BITS     = 32;
    localparam int MUL_BITS     = 32;
    localparam int DIV_BITS     = 64;

    localparam logic [31:0] PI_Q24       = 32'd52707179;
    localparam logic [31:0] PI_Q16       = 32'd205887;
    localparam logic [31:0] MICRO        = 32'd1000000;
    localparam logic [31:0] MILLI        = 32'd1000;
    localparam logic signed [23:0] INV_GAIN_Q20 = 24'sd636751;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_TRACK  = 2'd1;
    localparam logic [1:0] CFG_PPR    = 2'd2;

    localparam logic signed [63:0] POS_MAX = (64'sd1 <<< (POS_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] POS_MIN = -POS_MAX - 64'sd1;

    typedef logic signed [POS_BITS-1:0] t_pos;

    typedef struct packed {
        logic [15:0] left_pulses;
        logic [15:0] right_pulses;
        logic [23:0] elapsed_us;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x_um;
        logic signed [31:0] pos_y_um;
        logic [15:0]        heading_angle;
        logic signed [31:0] lin_speed_mm_s;
        logic signed [31:0] ang_speed_mrad_s;
    } t_out_item;

    // atan(2^-i) as a binary angle, 2^32 per turn
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic t_pos sat_pos(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = v;
        if (v > POS_MAX) c = POS_MAX;
        if (v < POS_MIN) c = POS_MIN;
        return POS_BITS'(c);
    endfunction

    function automatic logic signed [31:0] sat32(input t_pos v);
        logic signed [63:0] e;
        logic signed [63:0] c;
        e = 64'(v);
        c = e;
        if (e > 64'sd2147483647) c = 64'sd2147483647;
        if (e < -64'sd2147483648) c = -64'sd2147483648;
        return 32'(c);
    endfunction

endpackage

[rtl/ddo_in_if.sv]
interface ddo_in_if;
    logic               valid;
    logic               ready;
    ddo_pkg::t_in_item  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[rtl/ddo_out_if.sv]
interface ddo_out_if;
    logic               valid;
    logic               ready;
    ddo_pkg::t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[rtl/diff_drive_odometry.sv]
// each item runs 11 multiplies, 5 divides and CORDIC_STEPS CORDIC steps in sequence;
// multiplies and divides share the 65-bit add/subtract unit, one multiplier bit or quotient bit per cycle
// a new item is taken only when idle, after the last item is through, and also while the last result waits
// reset (synchronous, active low): registers to 50/200/8, pose and heading to zero
// result register empty after reset
module diff_drive_odometry (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    ddo_in_if.sink      i_in,
    ddo_out_if.source   o_out
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NEXT = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_CORD = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [4:0] PH_R1000  = 5'd0;
    localparam logic [4:0] PH_SUMN   = 5'd1;
    localparam logic [4:0] PH_PI24   = 5'd2;
    localparam logic [4:0] PH_STEPD  = 5'd3;
    localparam logic [4:0] PH_CORD   = 5'd4;
    localparam logic [4:0] PH_MULC   = 5'd5;
    localparam logic [4:0] PH_UPDX   = 5'd6;
    localparam logic [4:0] PH_UPDY   = 5'd7;
    localparam logic [4:0] PH_RAD    = 5'd8;
    localparam logic [4:0] PH_HDIV   = 5'd9;
    localparam logic [4:0] PH_HUPD   = 5'd10;
    localparam logic [4:0] PH_PI16   = 5'd11;
    localparam logic [4:0] PH_URDIV  = 5'd12;
    localparam logic [4:0] PH_URAD   = 5'd13;
    localparam logic [4:0] PH_LINDIV = 5'd14;
    localparam logic [4:0] PH_LIN    = 5'd15;
    localparam logic [4:0] PH_ANGDIV = 5'd16;
    localparam logic [4:0] PH_ANG    = 5'd17;

    localparam logic [5:0] MUL_LAST  = 6'(ddo_pkg::MUL_BITS - 1);
    localparam logic [5:0] DIV_LAST  = 6'(ddo_pkg::DIV_BITS - 1);
    localparam logic [5:0] CORD_LAST = 6'(ddo_pkg::CORDIC_STEPS - 1);

    logic [2:0]  r_state, n_state;
    logic [4:0]  r_ph, n_ph;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_a, n_a;
    logic [31:0] r_m, n_m;
    logic [63:0] r_rem, n_rem;
    logic signed [23:0] r_cx, n_cx;
    logic signed [23:0] r_cy, n_cy;
    logic signed [32:0] r_cz, n_cz;
    logic [39:0] r_step, n_step;
    logic [25:0] r_rad, n_rad;
    logic [24:0] r_pd, n_pd;
    logic [47:0] r_urad, n_urad;
    logic [31:0] r_lin, n_lin;
    logic [31:0] r_ang, n_ang;
    logic [15:0] r_nl, r_nr;
    logic [23:0] r_dt;
    ddo_pkg::t_pos r_xa, n_xa;
    ddo_pkg::t_pos r_ya, n_ya;
    logic [31:0] r_hd, n_hd;
    logic [9:0]  r_radius;
    logic [11:0] r_track;
    logic [12:0] r_ppr;
    logic        r_ovalid, n_ovalid;
    ddo_pkg::t_out_item r_out, n_out;

    logic [9:0]  rad_eff;
    logic [11:0] trk_eff;
    logic [12:0] ppr_eff;
    logic        turn_neg;
    logic [15:0] diff_abs;
    logic        in_take;

    // shared add/subtract unit
    logic [64:0] alu_a, alu_b, alu_y;
    logic        alu_sub;

    logic signed [23:0] cx_sh, cy_sh;
    logic signed [32:0] atan_v;
    logic signed [24:0] cos_v, sin_v, cs_v;
    logic        cs_neg;
    logic [31:0] cs_mag;
    logic [63:0] rnd;
    logic signed [63:0] dpos, pos_sum;
    logic        ang_big;

    assign rad_eff  = (r_radius == '0) ? 10'd1 : r_radius;
    assign trk_eff  = (r_track == '0) ? 12'd1 : r_track;
    assign ppr_eff  = (r_ppr == '0) ? 13'd1 : r_ppr;
    assign turn_neg = r_nr < r_nl;
    assign diff_abs = turn_neg ? (r_nl - r_nr) : (r_nr - r_nl);
    assign in_take  = i_in.valid && i_in.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    always_comb begin
        alu_sub = (r_state == S_DIV);
        if (alu_sub) begin
            alu_a = {r_rem, r_acc[63]};
            alu_b = {1'b0, r_a};
        end else begin
            alu_a = {1'b0, r_acc[62:0], 1'b0};
            alu_b = r_m[31] ? {1'b0, r_a} : '0;
        end
        alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    always_comb begin
        cx_sh  = r_cx >>> r_cnt[4:0];
        cy_sh  = r_cy >>> r_cnt[4:0];
        atan_v = 33'(ddo_pkg::atan_lut(r_cnt[4:0]));
    end

    // quadrant fold of the rotated vector
    always_comb begin
        unique case (r_hd[31:30])
            2'd0: begin cos_v = 25'(r_cx);  sin_v = 25'(r_cy);  end
            2'd1: begin cos_v = -25'(r_cy); sin_v = 25'(r_cx);  end
            2'd2: begin cos_v = -25'(r_cx); sin_v = -25'(r_cy); end
            default: begin cos_v = 25'(r_cy); sin_v = -25'(r_cx); end
        endcase
        cs_v   = (r_ph == PH_MULC) ? cos_v : sin_v;
        cs_neg = cs_v[24];
        cs_mag = 32'(cs_neg ? -cs_v : cs_v);
    end

    // x takes the sign of cos, y the sign of sin
    always_comb begin
        rnd     = (r_acc + 64'h80000) >> 20;
        dpos    = ((r_ph == PH_UPDX) ? cos_v[24] : sin_v[24]) ? -$signed(rnd) : $signed(rnd);
        pos_sum = ((r_ph == PH_UPDX) ? 64'(r_xa) : 64'(r_ya)) + dpos;
        ang_big = |r_acc[63:31];
    end

    always_comb begin
        n_state  = r_state;
        n_ph     = r_ph;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_a      = r_a;
        n_m      = r_m;
        n_rem    = r_rem;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_cz     = r_cz;
        n_step   = r_step;
        n_rad    = r_rad;
        n_pd     = r_pd;
        n_urad   = r_urad;
        n_lin    = r_lin;
        n_ang    = r_ang;
        n_xa     = r_xa;
        n_ya     = r_ya;
        n_hd     = r_hd;
        n_out    = r_out;
        n_ovalid = r_ovalid && !o_out.ready;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_NEXT;
                    n_ph    = PH_R1000;
                end
            end
            S_MUL: begin
                n_acc = alu_y[63:0];
                n_m   = {r_m[30:0], 1'b0};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == MUL_LAST) n_state = S_NEXT;
            end
            S_DIV: begin
                n_rem = alu_y[64] ? alu_a[63:0] : alu_y[63:0];
                n_acc = {r_acc[62:0], !alu_y[64]};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == DIV_LAST) n_state = S_NEXT;
            end
            S_CORD: begin
                if (!r_cz[32]) begin
                    n_cx = r_cx - cy_sh;
                    n_cy = r_cy + cx_sh;
                    n_cz = r_cz - atan_v;
                end else begin
                    n_cx = r_cx + cy_sh;
                    n_cy = r_cy - cx_sh;
                    n_cz = r_cz + atan_v;
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == CORD_LAST) n_state = S_NEXT;
            end
            S_FIN: begin
                if (!r_ovalid || o_out.ready) begin
                    n_out.pos_x_um         = ddo_pkg::sat32(r_xa);
                    n_out.pos_y_um         = ddo_pkg::sat32(r_ya);
                    n_out.heading_angle    = r_hd[31:16];
                    n_out.lin_speed_mm_s   = r_lin;
                    n_out.ang_speed_mrad_s = r_ang;
                    n_ovalid               = 1'b1;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                // S_NEXT: take the last result and launch the next operation
                n_cnt   = '0;
                n_rem   = '0;
                n_ph    = r_ph + 5'd1;
                n_state = S_MUL;
                case (r_ph) inside
                    PH_R1000: begin
                        n_a = 64'(rad_eff); n_m = ddo_pkg::MILLI; n_acc = '0;
                    end
                    PH_SUMN: begin
                        n_a = r_acc; n_m = 32'(17'(r_nl) + 17'(r_nr)); n_acc = '0;
                    end
                    PH_PI24: begin
                        n_a = r_acc; n_m = ddo_pkg::PI_Q24; n_acc = '0;
                    end
                    PH_STEPD: begin
                        n_acc   = r_acc + (64'(ppr_eff) << 23);
                        n_a     = 64'(ppr_eff) << 24;
                        n_state = S_DIV;
                    end
                    PH_CORD: begin
                        n_step  = r_acc[39:0];
                        n_cx    = ddo_pkg::INV_GAIN_Q20;
                        n_cy    = '0;
                        n_cz    = {3'b000, r_hd[29:0]};
                        n_state = S_CORD;
                    end
                    PH_MULC: begin
                        n_a = 64'(r_step); n_m = cs_mag; n_acc = '0;
                    end
                    PH_UPDX: begin
                        n_xa = ddo_pkg::sat_pos(pos_sum);
                        n_a = 64'(r_step); n_m = cs_mag; n_acc = '0;
                    end
                    PH_UPDY: begin
                        n_ya = ddo_pkg::sat_pos(pos_sum);
                        n_a = 64'(rad_eff); n_m = 32'(diff_abs); n_acc = '0;
                    end
                    PH_RAD: begin
                        n_rad = r_acc[25:0];
                        n_a = 64'(ppr_eff); n_m = 32'(trk_eff); n_acc = '0;
                    end
                    PH_HDIV: begin
                        n_pd    = r_acc[24:0];
                        n_acc   = (64'(r_rad) << 31) + 64'(r_acc[24:1]);
                        n_a     = 64'(r_acc[24:0]);
                        n_state = S_DIV;
                    end
                    PH_HUPD: begin
                        n_hd = turn_neg ? (r_hd - r_acc[31:0]) : (r_hd + r_acc[31:0]);
                        n_a = 64'(r_rad); n_m = ddo_pkg::MICRO; n_acc = '0;
                    end
                    PH_PI16: begin
                        n_a = r_acc; n_m = ddo_pkg::PI_Q16; n_acc = '0;
                    end
                    PH_URDIV: begin
                        n_acc   = r_acc + (64'(r_pd) << 15);
                        n_a     = 64'(r_pd) << 16;
                        n_state = S_DIV;
                    end
                    PH_URAD: begin
                        n_urad = r_acc[47:0];
                        n_a = 64'(r_step); n_m = ddo_pkg::MILLI; n_acc = '0;
                    end
                    PH_LINDIV, PH_ANGDIV: begin
                        n_acc   = r_acc + 64'(r_dt[23:1]);
                        n_a     = 64'(r_dt);
                        n_state = S_DIV;
                    end
                    PH_LIN: begin
                        n_lin = ang_big ? 32'h7FFFFFFF : r_acc[31:0];
                        n_a = 64'(r_urad); n_m = ddo_pkg::MILLI; n_acc = '0;
                    end
                    default: begin
                        if (!turn_neg) n_ang = ang_big ? 32'h7FFFFFFF : r_acc[31:0];
                        else n_ang = ang_big ? 32'h80000000 : -r_acc[31:0];
                        n_state = S_FIN;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_a    <= n_a;
        r_m    <= n_m;
        r_rem  <= n_rem;
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_cz   <= n_cz;
        r_step <= n_step;
        r_rad  <= n_rad;
        r_pd   <= n_pd;
        r_urad <= n_urad;
        r_lin  <= n_lin;
        r_ang  <= n_ang;
        r_out  <= n_out;
        if (in_take) begin
            r_nl <= i_in.data.left_pulses;
            r_nr <= i_in.data.right_pulses;
            r_dt <= (i_in.data.elapsed_us == '0) ? 24'd1 : i_in.data.elapsed_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ph     <= PH_R1000;
            r_ovalid <= 1'b0;
            r_xa     <= '0;
            r_ya     <= '0;
            r_hd     <= '0;
            r_radius <= 10'd50;
            r_track  <= 12'd200;
            r_ppr    <= 13'd8;
        end else begin
            r_state  <= n_state;
            r_ph     <= n_ph;
            r_ovalid <= n_ovalid;
            r_xa     <= n_xa;
            r_ya     <= n_ya;
            r_hd     <= n_hd;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ddo_pkg::CFG_RADIUS: r_radius <= i_cfg_data[9:0];
                    ddo_pkg::CFG_TRACK:  r_track  <= i_cfg_data[11:0];
                    ddo_pkg::CFG_PPR:    r_ppr    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_a != '0)
        else $error("divide by zero in shared unit");

    a_cord_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CORD |-> r_cnt <= CORD_LAST)
        else $error("cordic step count out of range");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_state == S_NEXT && r_ph == PH_R1000)
        else $error("item did not start the sequence");

    a_fin_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && !r_ovalid |=> r_ovalid && r_state == S_IDLE)
        else $error("result not loaded");

endmodule
